[rtl/bcs_pkg.sv]
// Shared constants and control types for the bit chunk splitter.
package bcs_pkg;

    // Word and store geometry
    localparam int WORD_BITS       = 64;
    localparam int WORD_SH_W       = $clog2(WORD_BITS);
    localparam int MAX_CHUNK_WORDS = 4;
    localparam int STORE_WORDS     = MAX_CHUNK_WORDS + 1;
    localparam int STORE_W         = WORD_BITS * STORE_WORDS;
    localparam int MAX_CHUNK_BITS  = WORD_BITS * MAX_CHUNK_WORDS;

    // Register field widths
    localparam int CHUNK_BITS_W = 9;
    localparam int COUNT_W      = 24;
    localparam int STORE_IDX_W  = CHUNK_BITS_W - WORD_SH_W;
    localparam int SHIFT_W      = WORD_SH_W + 1;

    // Configuration channel
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BITS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_COUNT = CFG_INDEX_W'(1);

    localparam logic [CHUNK_BITS_W-1:0] RESET_CHUNK_BITS = CHUNK_BITS_W'(64);

    // Item command codes
    localparam logic CMD_WORD  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic insert;   // OR the accepted word into the store
        logic emit;     // load one chunk word into the output register
        logic flush;    // current chunk comes from a flush item
    } bcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic chunks_zero;   // run finished, items are dropped
        logic insert_emits;  // a word insert leaves at least one full chunk
        logic last_word;     // the next emitted word closes its chunk
        logic more_after;    // another chunk follows the current one
    } bcs_status_t;

endpackage

[rtl/bcs_in_if.sv]
// Input item channel: command and source word.
interface bcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [bcs_pkg::WORD_BITS-1:0] word_in;

    modport source (output valid, output cmd, output word_in, input ready);
    modport sink   (input valid, input cmd, input word_in, output ready);
endinterface

[rtl/bcs_out_if.sv]
// Result channel: one chunk word with its markers.
interface bcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [bcs_pkg::WORD_BITS-1:0] word_out;
    logic                          chunk_end;
    logic                          run_end;
    logic                          all_done;

    modport source (output valid, output word_out, output chunk_end, output run_end,
                    output all_done, input ready);
    modport sink   (input valid, input word_out, input chunk_end, input run_end,
                    input all_done, output ready);
endinterface

[rtl/bcs_cfg_if.sv]
// Configuration write channel: register index and write data.
interface bcs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bcs_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [bcs_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/bcs_ctrl.sv]
// Controller: sequences item acceptance and chunk word output.
module bcs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bcs_pkg::bcs_status_t status,
    output bcs_pkg::bcs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;
    logic   load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Output register can take a word when empty or being drained
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.insert     = 1'b0;
        cmd.emit       = 1'b0;
        cmd.flush      = flush_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !status.chunks_zero)
                begin
                    if (in_cmd == bcs_pkg::CMD_FLUSH)
                    begin
                        flush_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        flush_next = 1'b0;
                        if (status.insert_emits)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last_word && (flush_reg || !status.more_after))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/bcs_dp.sv]
// Datapath: configuration, bit store, counters and output register.
module bcs_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [bcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [bcs_pkg::WORD_BITS-1:0]       word_in,
    input  bcs_pkg::bcs_cmd_t                   cmd,
    output bcs_pkg::bcs_status_t                status,
    output logic [bcs_pkg::WORD_BITS-1:0]       word_out,
    output logic                                chunk_end,
    output logic                                run_end,
    output logic                                all_done
);

    localparam int CB_W = bcs_pkg::CHUNK_BITS_W;
    localparam int WB   = bcs_pkg::WORD_BITS;

    logic [CB_W-1:0]             chunk_bits_reg, chunk_bits_next;
    logic [bcs_pkg::COUNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic [bcs_pkg::COUNT_W-1:0] chunks_left_reg, chunks_left_next;
    logic [CB_W-1:0]             bits_held_reg, bits_held_next;
    logic [bcs_pkg::STORE_IDX_W-1:0] word_idx_reg, word_idx_next;
    logic [WB-1:0] store_reg  [bcs_pkg::STORE_WORDS];
    logic [WB-1:0] store_next [bcs_pkg::STORE_WORDS];

    logic [WB-1:0] word_out_reg, word_out_next;
    logic          chunk_end_reg, chunk_end_next;
    logic          run_end_reg, run_end_next;
    logic          all_done_reg, all_done_next;

    logic [CB_W-1:0]                 cfg_width;
    logic [CB_W-1:0]                 width_m1;
    logic [bcs_pkg::WORD_SH_W-1:0]   rem;
    logic [bcs_pkg::STORE_IDX_W-1:0] last_idx;
    logic                            last_word;
    logic [CB_W-1:0]                 held_after;
    logic [bcs_pkg::COUNT_W-1:0]     chunks_after;
    logic                            more_after;
    logic [WB-1:0]                   mask;
    logic [bcs_pkg::SHIFT_W-1:0]     sh_amt;
    logic [bcs_pkg::STORE_W-1:0]     flat;
    logic [bcs_pkg::STORE_W-1:0]     flat_sh;
    logic [bcs_pkg::STORE_IDX_W-1:0] ins_idx;
    logic [bcs_pkg::STORE_IDX_W-1:0] ins_idx_hi;
    logic [bcs_pkg::WORD_SH_W-1:0]   ins_sh;
    logic [2*WB-1:0]                 ins_wide;

    // Width written to chunk_bits, held in its usable range
    always_comb
    begin
        cfg_width = cfg_data[CB_W-1:0];
        if (cfg_width == '0)
        begin
            cfg_width = CB_W'(1);
        end
        else if (cfg_width > CB_W'(bcs_pkg::MAX_CHUNK_BITS))
        begin
            cfg_width = CB_W'(bcs_pkg::MAX_CHUNK_BITS);
        end
    end

    // Chunk geometry and what follows the current chunk
    assign width_m1     = chunk_bits_reg - CB_W'(1);
    assign rem          = chunk_bits_reg[bcs_pkg::WORD_SH_W-1:0];
    assign last_idx     = width_m1[CB_W-1:bcs_pkg::WORD_SH_W];
    assign last_word    = (word_idx_reg == last_idx);
    assign held_after   = (bits_held_reg > chunk_bits_reg) ?
                          (bits_held_reg - chunk_bits_reg) : '0;
    assign chunks_after = chunks_left_reg - bcs_pkg::COUNT_W'(1);
    assign more_after   = (held_after >= chunk_bits_reg) && (chunks_after != '0);
    assign mask         = (last_word && (rem != '0)) ?
                          ((WB'(1) << rem) - WB'(1)) : '1;

    // A whole word drops per non-final word, the remainder bits on the last
    assign sh_amt = (last_word && (rem != '0)) ? {1'b0, rem}
                                               : bcs_pkg::SHIFT_W'(WB);

    always_comb
    begin
        for (int k = 0; k < bcs_pkg::STORE_WORDS; k++)
        begin
            flat[k*WB +: WB] = store_reg[k];
        end
    end

    assign flat_sh = flat >> sh_amt;

    // Insert position of a new word above the held bits
    assign ins_idx    = bits_held_reg[CB_W-1:bcs_pkg::WORD_SH_W];
    assign ins_idx_hi = ins_idx + bcs_pkg::STORE_IDX_W'(1);
    assign ins_sh     = bits_held_reg[bcs_pkg::WORD_SH_W-1:0];
    assign ins_wide   = {{WB{1'b0}}, word_in} << ins_sh;

    // Status to the controller
    assign status.chunks_zero  = (chunks_left_reg == '0);
    assign status.insert_emits = ({1'b0, bits_held_reg} + (CB_W+1)'(WB))
                                 >= {1'b0, chunk_bits_reg};
    assign status.last_word    = last_word;
    assign status.more_after   = more_after;

    // Next state of registers and store
    always_comb
    begin
        chunk_bits_next  = chunk_bits_reg;
        chunk_count_next = chunk_count_reg;
        chunks_left_next = chunks_left_reg;
        bits_held_next   = bits_held_reg;
        word_idx_next    = word_idx_reg;
        store_next       = store_reg;
        word_out_next    = word_out_reg;
        chunk_end_next   = chunk_end_reg;
        run_end_next     = run_end_reg;
        all_done_next    = all_done_reg;

        priority if (cfg_valid && ((cfg_index == bcs_pkg::REG_CHUNK_BITS) ||
                                   (cfg_index == bcs_pkg::REG_CHUNK_COUNT)))
        begin
            // Any register write starts a new run
            if (cfg_index == bcs_pkg::REG_CHUNK_BITS)
            begin
                chunk_bits_next = cfg_width;
            end
            else
            begin
                chunk_count_next = cfg_data[bcs_pkg::COUNT_W-1:0];
            end
            chunks_left_next = (cfg_index == bcs_pkg::REG_CHUNK_COUNT) ?
                               cfg_data[bcs_pkg::COUNT_W-1:0] : chunk_count_reg;
            bits_held_next   = '0;
            word_idx_next    = '0;
            for (int k = 0; k < bcs_pkg::STORE_WORDS; k++)
            begin
                store_next[k] = '0;
            end
        end
        else if (cmd.insert)
        begin
            for (int k = 0; k < bcs_pkg::STORE_WORDS; k++)
            begin
                if (bcs_pkg::STORE_IDX_W'(k) == ins_idx)
                begin
                    store_next[k] = store_reg[k] | ins_wide[WB-1:0];
                end
                if (bcs_pkg::STORE_IDX_W'(k) == ins_idx_hi)
                begin
                    store_next[k] = store_reg[k] | ins_wide[2*WB-1:WB];
                end
            end
            bits_held_next = bits_held_reg + CB_W'(WB);
        end
        else if (cmd.emit)
        begin
            word_out_next  = store_reg[0] & mask;
            chunk_end_next = last_word;
            run_end_next   = last_word && (cmd.flush || !more_after);
            all_done_next  = (chunks_after == '0);
            if (last_word)
            begin
                word_idx_next    = '0;
                chunks_left_next = chunks_after;
                bits_held_next   = cmd.flush ? '0 : held_after;
            end
            else
            begin
                word_idx_next = word_idx_reg + bcs_pkg::STORE_IDX_W'(1);
            end
            for (int k = 0; k < bcs_pkg::STORE_WORDS; k++)
            begin
                store_next[k] = (last_word && cmd.flush) ? '0 : flat_sh[k*WB +: WB];
            end
        end
        else
        begin
            word_idx_next = word_idx_reg;
        end
    end

    // Control and store registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bits_reg  <= bcs_pkg::RESET_CHUNK_BITS;
            chunk_count_reg <= '0;
            chunks_left_reg <= '0;
            bits_held_reg   <= '0;
            word_idx_reg    <= '0;
            for (int k = 0; k < bcs_pkg::STORE_WORDS; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else
        begin
            chunk_bits_reg  <= chunk_bits_next;
            chunk_count_reg <= chunk_count_next;
            chunks_left_reg <= chunks_left_next;
            bits_held_reg   <= bits_held_next;
            word_idx_reg    <= word_idx_next;
            store_reg       <= store_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        word_out_reg  <= word_out_next;
        chunk_end_reg <= chunk_end_next;
        run_end_reg   <= run_end_next;
        all_done_reg  <= all_done_next;
    end

    assign word_out  = word_out_reg;
    assign chunk_end = chunk_end_reg;
    assign run_end   = run_end_reg;
    assign all_done  = all_done_reg;

endmodule

[rtl/bit_chunk_splitter.sv]
// Bit chunk splitter top level: a 64-bit word stream is cut into fixed-width chunks.
//
// Source words arrive least significant first and are packed into a five-word
// bit store; each chunk of chunk_bits bits leaves as ceil(chunk_bits/64) words,
// lowest first, top bits cleared, with chunk_end on its last word, run_end on the
// last word an item causes and all_done on every word of the final chunk. A flush
// item gives one chunk from the held bits padded with zeros and clears them.
// Once chunk_count chunks are out, items are taken and dropped. A write to either
// register restarts the run. Items are handled one at a time: a new item waits until
// the last item's words are in the output register; one output word leaves per cycle
// while the sink is ready, and a source word that completes no chunk does not hold
// the input. The single output word register and its store shifter set this pace.
module bit_chunk_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    bcs_in_if.sink     in_ch,
    bcs_out_if.source  out_ch,
    bcs_cfg_if.sink    cfg
);

    bcs_pkg::bcs_cmd_t    cmd;
    bcs_pkg::bcs_status_t status;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    bcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.reg_index),
        .cfg_data  (cfg.wdata),
        .word_in   (in_ch.word_in),
        .cmd       (cmd),
        .status    (status),
        .word_out  (out_ch.word_out),
        .chunk_end (out_ch.chunk_end),
        .run_end   (out_ch.run_end),
        .all_done  (out_ch.all_done)
    );

`ifndef SYNTHESIS
    // A flush transfer in a live run occupies the block for the following cycle
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.cmd == bcs_pkg::CMD_FLUSH) &&
         !status.chunks_zero) |=> !in_ch.ready)
        else $error("flush transfer did not start chunk output");

    // run_end only closes a chunk
    a_run_end_on_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.run_end) |-> out_ch.chunk_end)
        else $error("run_end without chunk_end");

    // The final chunk always ends its item's output
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.all_done && out_ch.chunk_end) |-> out_ch.run_end)
        else $error("final chunk without run_end");
`endif

endmodule
